@@ design/sde_pkg.sv @@
// shared types, constants and symbol tables for the symbol display encoder
package sde_pkg;

  localparam int OffsetLimitDefault = 30;

  localparam logic [7:0] BYTE_LEFT   = 8'h08;
  localparam logic [7:0] BYTE_RIGHT  = 8'h09;
  localparam logic [7:0] BYTE_DOWN   = 8'h0a;
  localparam logic [7:0] BYTE_UP     = 8'h0b;
  localparam logic [7:0] BYTE_SP_ON  = 8'h12;
  localparam logic [7:0] BYTE_SP_OFF = 8'h11;
  localparam logic [7:0] BYTE_PAD    = 8'h20;
  localparam logic [7:0] BYTE_HDR0   = 8'h40;
  localparam logic [7:0] BYTE_HDR2   = 8'h05;
  localparam logic [7:0] BYTE_HDR3   = 8'h02;
  localparam logic [7:0] BYTE_HDR4   = 8'h01;
  localparam logic [7:0] BYTE_HDR5   = 8'h00;
  localparam logic [7:0] HDR_BASE    = 8'd5;

  // register indexes
  localparam logic [2:0] REG_SPAN_X   = 3'd0;
  localparam logic [2:0] REG_SPAN_Y   = 3'd1;
  localparam logic [2:0] REG_CLIP_L   = 3'd2;
  localparam logic [2:0] REG_CLIP_R   = 3'd3;
  localparam logic [2:0] REG_CLIP_B   = 3'd4;
  localparam logic [2:0] REG_CLIP_T   = 3'd5;
  localparam logic [2:0] REG_SUPPRESS = 3'd6;

  // categories
  localparam logic [3:0] CAT_WX    = 4'd1;
  localparam logic [3:0] CAT_CLOUD = 4'd2;
  localparam logic [3:0] CAT_ICE   = 4'd3;
  localparam logic [3:0] CAT_TEND  = 4'd4;
  localparam logic [3:0] CAT_PAST  = 4'd5;
  localparam logic [3:0] CAT_SKY   = 4'd6;
  localparam logic [3:0] CAT_SPEC  = 4'd7;
  localparam logic [3:0] CAT_TURB  = 4'd8;
  localparam logic [3:0] CAT_MARK  = 4'd9;
  localparam logic [13:0] CODE_SLASH = 14'd31;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic decide;   // evaluate clip and lookup
    logic emit;     // drive a byte into the output register
  } sde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;     // point yields no output
    logic done;     // last byte placed
  } sde_stat_t;

  typedef logic [5:0][7:0] sym_t;

  function automatic sym_t wx_entry(input logic [6:0] i);
    sym_t r;
    r = '0;
    case (i)
      7'd4: r[0]=8'h1c; 7'd5: r[0]=8'h1d; 7'd6: r[0]=8'h1e; 7'd7: r[0]=8'h1f;
      7'd8: r[0]=8'h20; 7'd9: r[0]=8'h21; 7'd10: r[0]=8'h22; 7'd11: r[0]=8'h23;
      7'd12: r[0]=8'h24; 7'd13: r[0]=8'h25; 7'd14: r[0]=8'h26; 7'd15: r[0]=8'h27;
      7'd16: r[0]=8'h28; 7'd17: r[0]=8'h29; 7'd18: r[0]=8'h2a; 7'd19: r[0]=8'h2b;
      7'd20: r[1:0]={8'h31,8'h2c}; 7'd21: r[1:0]={8'h31,8'h2d};
      7'd22: r[1:0]={8'h31,8'h2e}; 7'd23: r[1:0]={8'h31,8'h2f};
      7'd24: r[1:0]={8'h31,8'h30};
      7'd25: r={8'h31,8'h0a,8'h2d,8'h08,8'h0b,8'h36};
      7'd26: r={8'h31,8'h0a,8'h2e,8'h08,8'h0b,8'h36};
      7'd27: r={8'h31,8'h0a,8'h4d,8'h08,8'h0b,8'h36};
      7'd28: r[1:0]={8'h31,8'h35}; 7'd29: r[1:0]={8'h31,8'h29};
      7'd30: r[2:0]={8'h39,8'h09,8'h37}; 7'd31: r[0]=8'h37;
      7'd32: r[2:0]={8'h37,8'h08,8'h39};
      7'd33: r[2:0]={8'h39,8'h09,8'h3a}; 7'd34: r[0]=8'h3a;
      7'd35: r[2:0]={8'h3a,8'h08,8'h39};
      7'd36: r[0]=8'h3b; 7'd37: r[0]=8'h3c; 7'd38: r[0]=8'h3d; 7'd39: r[0]=8'h3e;
      7'd40: r[1:0]={8'h53,8'h48}; 7'd41: r[0]=8'h3f;
      7'd42: r[2:0]={8'h39,8'h09,8'h40}; 7'd43: r[2:0]={8'h39,8'h09,8'h35};
      7'd44: r[0]=8'h40; 7'd45: r[0]=8'h35;
      7'd46: r[2:0]={8'h40,8'h08,8'h39}; 7'd47: r[2:0]={8'h35,8'h08,8'h39};
      7'd48: r[0]=8'h41; 7'd49: r[0]=8'h42;
      7'd50: r[0]=8'h2c; 7'd51: r[1:0]={8'h2c,8'h2c}; 7'd52: r[0]=8'h43;
      7'd53: r={8'h2c,8'h0a,8'h2c,8'h0b,8'h2c,8'h08};
      7'd54: r[3:0]={8'h2c,8'h08,8'h0b,8'h43};
      7'd55: r[3:0]={8'h2c,8'h43,8'h2c,8'h08};
      7'd56: r[0]=8'h44; 7'd57: r[0]=8'h45; 7'd58: r[0]=8'h49;
      7'd59: r[3:0]={8'h2c,8'h08,8'h0b,8'h49};
      7'd60: r[0]=8'h2d; 7'd61: r[1:0]={8'h2d,8'h2d}; 7'd62: r[0]=8'h4f;
      7'd63: r={8'h2d,8'h0a,8'h2d,8'h0b,8'h2d,8'h08};
      7'd64: r[3:0]={8'h2d,8'h08,8'h0b,8'h4f};
      7'd65: r[3:0]={8'h2d,8'h4f,8'h2d,8'h08};
      7'd66: r[0]=8'h46; 7'd67: r[0]=8'h47; 7'd68: r[0]=8'h2f;
      7'd69: r[3:0]={8'h2e,8'h08,8'h0b,8'h2f};
      7'd70: r[0]=8'h2e; 7'd71: r[1:0]={8'h2e,8'h2e}; 7'd72: r[0]=8'h59;
      7'd73: r={8'h2e,8'h0a,8'h2e,8'h0b,8'h2e,8'h08};
      7'd74: r[3:0]={8'h2e,8'h08,8'h0b,8'h59};
      7'd75: r[3:0]={8'h2e,8'h59,8'h2e,8'h08};
      7'd76: r[0]=8'h4a; 7'd77: r[0]=8'h4b; 7'd78: r[0]=8'h4c; 7'd79: r[0]=8'h4d;
      7'd80: r[3:0]={8'h2d,8'h08,8'h0b,8'h36};
      7'd81: r[3:0]={8'h2d,8'h08,8'h0b,8'h4e};
      7'd82: r[3:0]={8'h4f,8'h08,8'h0b,8'h36};
      7'd83: r[3:0]={8'h2f,8'h08,8'h0b,8'h36};
      7'd84: r[3:0]={8'h2f,8'h08,8'h0b,8'h4e};
      7'd85: r[3:0]={8'h2e,8'h08,8'h0b,8'h36};
      7'd86: r[3:0]={8'h2e,8'h08,8'h0b,8'h4e};
      7'd87: r[3:0]={8'h4d,8'h08,8'h0b,8'h36};
      7'd88: r[3:0]={8'h4d,8'h08,8'h0b,8'h4e};
      7'd89: r[3:0]={8'h4d,8'h08,8'h0b,8'h36};
      7'd90: r[3:0]={8'h4d,8'h08,8'h0b,8'h4e};
      7'd91: r[1:0]={8'h51,8'h29}; 7'd92: r[1:0]={8'h52,8'h29};
      7'd93: r[1:0]={8'h55,8'h29}; 7'd94: r[1:0]={8'h57,8'h29};
      7'd95: r[3:0]={8'h2d,8'h08,8'h0b,8'h29};
      7'd96: r[3:0]={8'h4d,8'h08,8'h0b,8'h29};
      7'd97: r[3:0]={8'h2d,8'h08,8'h0b,8'h58};
      7'd98: r[3:0]={8'h37,8'h08,8'h0b,8'h29};
      7'd99: r[3:0]={8'h4d,8'h08,8'h0b,8'h58};
      7'd103: r[1:0]={8'h54,8'h29}; 7'd104: r[1:0]={8'h56,8'h29};
      7'd105: r[3:0]={8'h2e,8'h08,8'h0b,8'h29};
      7'd107: r[3:0]={8'h2e,8'h08,8'h0b,8'h58};
      default: r = '0;
    endcase
    return r;
  endfunction

  // single byte tables, selected by category; returns table byte, sets in_range
  function automatic logic [8:0] one_entry(input logic [3:0] cat, input logic [13:0] ic,
                                           input logic [4:0] tend);
    logic [7:0] b;
    logic       ok;
    b = 8'h00;
    ok = 1'b0;
    case (cat)
      CAT_CLOUD: begin
        ok = ic < 14'd30;
        case (ic[4:0])
          5'd1: b=8'h66; 5'd2: b=8'h67; 5'd3: b=8'h68; 5'd4: b=8'h69; 5'd5: b=8'h6a;
          5'd6: b=8'h6b; 5'd7: b=8'h6c; 5'd8: b=8'h6d; 5'd9: b=8'h6e;
          5'd11: b=8'h5d; 5'd12: b=8'h5e; 5'd13: b=8'h5f; 5'd14: b=8'h60;
          5'd15: b=8'h61; 5'd16: b=8'h62; 5'd17: b=8'h63; 5'd18: b=8'h64;
          5'd19: b=8'h65; 5'd21: b=8'h6f; 5'd22: b=8'h70; 5'd23: b=8'h71;
          5'd24: b=8'h72; 5'd25: b=8'h73; 5'd26: b=8'h74; 5'd27: b=8'h75;
          5'd28: b=8'h76; 5'd29: b=8'h77;
          default: b = 8'h00;
        endcase
      end
      CAT_ICE: begin
        ok = ic < 14'd11;
        case (ic[3:0])
          4'd3: b=8'h7d; 4'd5: b=8'h7e; 4'd8: b=8'h7f;
          default: b = 8'h00;
        endcase
      end
      CAT_TEND: begin
        ok = tend < 5'd9;
        case (tend)
          5'd0: b=8'h16; 5'd1: b=8'h17; 5'd3: b=8'h1a; 5'd5: b=8'h18;
          5'd6: b=8'h19; 5'd8: b=8'h1b;
          default: b = 8'h00;
        endcase
      end
      CAT_PAST: begin
        ok = ic < 14'd10;
        case (ic[3:0])
          4'd3: b=8'h37; 4'd4: b=8'h35; 4'd5: b=8'h2c; 4'd6: b=8'h2d;
          4'd7: b=8'h2e; 4'd8: b=8'h36; 4'd9: b=8'h29;
          default: b = 8'h00;
        endcase
      end
      CAT_SKY: begin
        ok = ic < 14'd11;
        case (ic[3:0])
          4'd0: b=8'h0e; 4'd1: b=8'h0f; 4'd2: b=8'h10; 4'd3: b=8'h13;
          4'd4: b=8'h14; 4'd5: b=8'h15; 4'd6: b=8'h01; 4'd7: b=8'h02;
          4'd8: b=8'h03; 4'd9: b=8'h04; 4'd10: b=8'h05;
          default: b = 8'h00;
        endcase
      end
      CAT_SPEC: begin
        ok = ic < 14'd41;
        case (ic[5:0])
          6'd0: b=8'h06; 6'd4: b=8'h34; 6'd5: b=8'h50; 6'd8: b=8'h07;
          6'd9: b=8'h07; 6'd10: b=8'h5a; 6'd11: b=8'h5b; 6'd12: b=8'h5a;
          6'd13: b=8'h5b; 6'd14: b=8'h31; 6'd15: b=8'h33; 6'd16: b=8'h32;
          6'd17: b=8'h39; 6'd18: b=8'h38; 6'd19: b=8'h51; 6'd20: b=8'h52;
          6'd21: b=8'h54; 6'd22: b=8'h56; 6'd23: b=8'h55; 6'd24: b=8'h57;
          6'd25: b=8'h78; 6'd26: b=8'h79; 6'd27: b=8'h78; 6'd28: b=8'h79;
          6'd29: b=8'h5c; 6'd30: b=8'h30; 6'd31: b=8'h2f;
          default: b = 8'h00;
        endcase
      end
      CAT_TURB: begin
        ok = ic < 14'd9;
        case (ic[3:0])
          4'd2: b=8'h7a; 4'd4: b=8'h7b; 4'd6: b=8'h7c;
          default: b = 8'h00;
        endcase
      end
      CAT_MARK: begin
        ok = ic < 14'd22;
        case (ic[4:0])
          5'd2: b=8'h0e; 5'd3: b=8'h34; 5'd4: b=8'h06; 5'd17: b=8'h03;
          5'd21: b=8'h07;
          default: b = 8'h00;
        endcase
      end
      default: begin
        b = 8'h00;
        ok = 1'b0;
      end
    endcase
    return {ok, b};
  endfunction

endpackage

@@ design/sde_ctrl.sv @@
// controller: sequences load, decision and byte emission for each point
module sde_ctrl
  import sde_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_slot,
  input  sde_stat_t stat,
  output sde_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEC  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC:  state_next = stat.drop ? S_IDLE : S_EMIT;
      S_EMIT: if (out_slot && stat.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall   = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.decide = (state == S_DEC);
  assign cmd.emit   = (state == S_EMIT) && out_slot;

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DEC)
    else $error("load did not move to decision");
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !cmd.emit)
    else $error("emit while idle");

endmodule

@@ design/sde_dp.sv @@
// datapath: clip test, string builder and header/string byte serializer
module sde_dp
  import sde_pkg::*;
#(
  parameter int OFFSET_LIMIT = OffsetLimitDefault
)(
  input  logic               clk,
  input  logic               rst,
  input  sde_cmd_t           cmd,
  output sde_stat_t          stat,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic               first_of_call,
  input  logic [3:0]         category,
  input  logic [13:0]        symbol_code,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [5:0]  x_offset,
  input  logic signed [5:0]  y_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  output logic               out_slot
);

  localparam logic [5:0] Lim = 6'(OFFSET_LIMIT);

  // configuration registers
  logic signed [1:0]  span_x, span_y;
  logic signed [15:0] clip_l, clip_r, clip_b, clip_t;
  logic               suppress;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_x <= 2'sd1; span_y <= 2'sd1;
      clip_l <= 16'sd0; clip_r <= 16'sd32767;
      clip_b <= 16'sd0; clip_t <= 16'sd32767;
      suppress <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPAN_X:   span_x <= cfg_data[1:0];
        REG_SPAN_Y:   span_y <= cfg_data[1:0];
        REG_CLIP_L:   clip_l <= cfg_data;
        REG_CLIP_R:   clip_r <= cfg_data;
        REG_CLIP_B:   clip_b <= cfg_data;
        REG_CLIP_T:   clip_t <= cfg_data;
        REG_SUPPRESS: suppress <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        first_r;
  logic [3:0]  cat_r;
  logic [13:0] code_r;
  logic signed [15:0] x_r, y_r;
  logic signed [5:0]  xo_r, yo_r;
  logic [4:0]  tend_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= first_of_call; cat_r <= category; code_r <= symbol_code;
      x_r <= x_coord; y_r <= y_coord; xo_r <= x_offset; yo_r <= y_offset;
      // code / 1000 by reciprocal: 14 bit code, result fits in 5 bits
      tend_r <= 5'(((32'(symbol_code) * 32'd8389) >> 23));
    end
  end

  // clip: span sign times difference, compare sign of difference
  function automatic logic outs(input logic signed [1:0] sp, input logic signed [15:0] p,
                                input logic signed [15:0] bd, input logic neg);
    logic signed [16:0] d;
    logic gt, lt;
    d = 17'(p) - 17'(bd);
    gt = (d > 0);
    lt = (d < 0);
    if (sp == 2'sd0) return 1'b0;
    if (sp[1]) return neg ? gt : lt;
    return neg ? lt : gt;
  endfunction

  logic clipped;
  assign clipped = outs(span_x, x_r, clip_l, 1'b1) | outs(span_x, x_r, clip_r, 1'b0) |
                   outs(span_y, y_r, clip_b, 1'b1) | outs(span_y, y_r, clip_t, 1'b0);

  // cursor step counts and direction
  function automatic logic [5:0] steps(input logic signed [5:0] off,
                                       input logic signed [1:0] sp);
    logic [5:0] a;
    a = off[5] ? 6'(-off) : off;
    if (a > Lim) a = Lim;
    if (sp == 2'sd0) return 6'd0;
    return 6'((7'(a) + 7'd1) >> 1);
  endfunction

  logic [5:0] nx, ny;
  logic       negx, negy;
  assign nx = steps(xo_r, span_x);
  assign ny = steps(yo_r, span_y);
  assign negx = (span_x != 2'sd0) && (xo_r != 6'sd0) && (xo_r[5] ^ span_x[1]);
  assign negy = (span_y != 2'sd0) && (yo_r != 6'sd0) && (yo_r[5] ^ span_y[1]);

  // symbol lookup
  sym_t       wx;
  logic [8:0] one;
  logic       slash, is_wx, wx_ok, blank;
  logic [2:0] nsym;
  assign wx    = wx_entry(code_r[6:0]);
  assign one   = one_entry(cat_r, code_r, tend_r);
  assign slash = (cat_r == CAT_SPEC) && (code_r == CODE_SLASH);
  assign is_wx = (cat_r == CAT_WX);
  assign wx_ok = is_wx && (code_r < 14'd110);

  always_comb begin
    nsym = 3'd0;
    if (wx_ok) begin
      for (int i = 0; i < 6; i++) if (wx[i] != 8'h00 && nsym == 3'(i)) nsym = 3'(i + 1);
    end else if (one[8]) begin
      nsym = 3'd1;
    end
  end
  assign blank = wx_ok ? (wx[0] == 8'h00) : (one[8] && one[7:0] == 8'h00);

  // stop flag and string layout registers
  logic       stopped, stopped_next, drop;
  logic [5:0] nx_r, ny_r;
  logic       negx_r, negy_r, slash_r;
  logic [2:0] nsym_r;
  sym_t       sym_r;
  logic [5:0] slen;
  logic [5:0] slen_r;

  assign slen = 6'(7'(nx) + 7'(ny) + 7'(nsym) + (slash ? 7'd0 : 7'd2));

  always_comb begin
    stopped_next = stopped;
    drop = 1'b0;
    if (cmd.decide) begin
      if (first_r) stopped_next = 1'b0;
      if (suppress || stopped_next) drop = 1'b1;
      else if (clipped || blank) begin
        drop = 1'b1;
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stopped <= 1'b0;
    else stopped <= stopped_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      nx_r <= nx; ny_r <= ny; negx_r <= negx; negy_r <= negy;
      slash_r <= slash; nsym_r <= nsym;
      slen_r <= slen + 6'(slen[0]);
      sym_r <= wx_ok ? wx : {40'h0, one[7:0]};
    end
  end

  // serializer position: byte index over header and string
  logic [5:0] pos;
  logic [5:0] total;
  logic [5:0] si;
  logic [7:0] b;
  assign total = 6'(7'(slen_r) + 7'd10);
  assign si = pos - 6'd10;

  always_comb begin
    logic [5:0] k;
    k = si;
    b = BYTE_PAD;
    case (pos)
      6'd0: b = BYTE_HDR0;
      6'd1: b = HDR_BASE + 8'(slen_r >> 1);
      6'd2: b = BYTE_HDR2;
      6'd3: b = BYTE_HDR3;
      6'd4: b = BYTE_HDR4;
      6'd5: b = BYTE_HDR5;
      6'd6: b = x_r[15:8];
      6'd7: b = x_r[7:0];
      6'd8: b = y_r[15:8];
      6'd9: b = y_r[7:0];
      default: begin
        if (k < nx_r) b = negx_r ? BYTE_LEFT : BYTE_RIGHT;
        else begin
          k = k - nx_r;
          if (k < ny_r) b = negy_r ? BYTE_DOWN : BYTE_UP;
          else begin
            k = k - ny_r;
            if (!slash_r && k == 6'd0) b = BYTE_SP_ON;
            else begin
              if (!slash_r) k = k - 6'd1;
              if (k < 6'(nsym_r)) b = sym_r[k[2:0]];
              else if (!slash_r && k == 6'(nsym_r)) b = BYTE_SP_OFF;
              else b = BYTE_PAD;
            end
          end
        end
      end
    endcase
  end

  logic is_last;
  assign is_last = (pos == total - 6'd1);

  // output register
  assign out_slot = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= 6'd0;
    end else begin
      if (!out_stall) out_valid <= 1'b0;
      if (cmd.decide) pos <= 6'd0;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        pos <= pos + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= b;
      last_byte <= is_last;
    end
  end

  assign stat.drop = drop;
  assign stat.done = is_last;

  a_drop_stops: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && drop && !suppress && !stopped_next |-> 1'b0 || clipped || blank || stopped)
    else $error("drop without cause");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted byte not presented");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> pos < total)
    else $error("serializer ran past end of string");

endmodule

@@ design/symbol_to_display_byte_encoder.sv @@
// top level of the symbol display encoder
// a point is captured on input transfer, decided in the decision state, then serialized
// new points stall until the current one is emitted or dropped; bytes go out at one byte per
//   cycle when out_stall is low, through the single output byte register
// reset: synchronous; registers go to their reset values, stop flag clears
module symbol_to_display_byte_encoder
  import sde_pkg::*;
#(
  parameter int OFFSET_LIMIT = OffsetLimitDefault
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               first_of_call,
  input  logic [3:0]         category,
  input  logic [13:0]        symbol_code,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [5:0]  x_offset,
  input  logic signed [5:0]  y_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last_byte
);

  sde_cmd_t  cmd;
  sde_stat_t stat;
  logic      out_slot;

  sde_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_slot, .stat, .cmd
  );

  sde_dp #(.OFFSET_LIMIT(OFFSET_LIMIT)) u_dp (
    .clk, .rst, .cmd, .stat,
    .cfg_wr(cfg_we), .cfg_idx(cfg_index), .cfg_data,
    .first_of_call, .category, .symbol_code, .x_coord, .y_coord,
    .x_offset, .y_offset,
    .out_valid, .out_stall, .out_byte, .last_byte, .out_slot
  );

endmodule

@@ test/symbol_to_display_byte_encoder_test.sv @@
// testbench for the symbol display encoder: random and directed points against a byte predictor
module symbol_to_display_byte_encoder_test;
  import sde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_LIMIT_TB = 30;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } disp_byte_t;

  typedef struct {
    logic              first;
    logic [3:0]        cat;
    logic [13:0]       code;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [5:0] xo;
    logic signed [5:0] yo;
  } point_t;

  // predicts the byte stream for each point and checks received bytes
  class byte_board;
    logic signed [1:0]  span_x, span_y;
    logic signed [15:0] clip_l, clip_r, clip_b, clip_t;
    logic               suppress;
    logic               stopped;
    disp_byte_t         pending[$];
    int                 errors;

    function new();
      span_x = 2'sd1; span_y = 2'sd1;
      clip_l = 0; clip_r = 16'sd32767; clip_b = 0; clip_t = 16'sd32767;
      suppress = 0; stopped = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_SPAN_X:   span_x = v[1:0];
        REG_SPAN_Y:   span_y = v[1:0];
        REG_CLIP_L:   clip_l = v;
        REG_CLIP_R:   clip_r = v;
        REG_CLIP_B:   clip_b = v;
        REG_CLIP_T:   clip_t = v;
        REG_SUPPRESS: suppress = v[0];
        default: ;
      endcase
    endfunction

    function int sgn(logic signed [1:0] s);
      return (s < 0) ? -1 : int'(s);
    endfunction

    function void add_steps(ref logic [7:0] s[$], input int off, input int span,
                            input logic [7:0] neg_b, input logic [7:0] pos_b);
      int n, k;
      if (off > OFFSET_LIMIT_TB) off = OFFSET_LIMIT_TB;
      if (off < -OFFSET_LIMIT_TB) off = -OFFSET_LIMIT_TB;
      n = off * span;
      k = ((n < 0 ? -n : n) + 1) / 2;
      repeat (k) s.push_back(n < 0 ? neg_b : pos_b);
    endfunction

    // table byte for single-byte categories: -1 blank, 0 out of range, 1 found
    function int single(int cat, int ic, output logic [7:0] b);
      byte unsigned cl[30] = '{0,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,
        0,8'h5d,8'h5e,8'h5f,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,
        0,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77};
      byte unsigned ic_t[11] = '{0,0,0,8'h7d,0,8'h7e,0,0,8'h7f,0,0};
      byte unsigned te[9] = '{8'h16,8'h17,0,8'h1a,0,8'h18,8'h19,0,8'h1b};
      byte unsigned pa[10] = '{0,0,0,8'h37,8'h35,8'h2c,8'h2d,8'h2e,8'h36,8'h29};
      byte unsigned sk[11] = '{8'h0e,8'h0f,8'h10,8'h13,8'h14,8'h15,1,2,3,4,5};
      byte unsigned sp[41] = '{8'h06,0,0,0,8'h34,8'h50,0,0,8'h07,8'h07,8'h5a,
        8'h5b,8'h5a,8'h5b,8'h31,8'h33,8'h32,8'h39,8'h38,8'h51,8'h52,
        8'h54,8'h56,8'h55,8'h57,8'h78,8'h79,8'h78,8'h79,8'h5c,8'h30,
        8'h2f,0,0,0,0,0,0,0,0,0};
      byte unsigned tu[9] = '{0,0,8'h7a,0,8'h7b,0,8'h7c,0,0};
      byte unsigned mk[22] = '{0,0,8'h0e,8'h34,8'h06,0,0,0,0,0,0,0,0,0,0,0,0,8'h03,0,0,0,8'h07};
      int v;
      b = 0;
      v = -2;
      case (cat)
        2: if (ic < 30) v = cl[ic];
        3: if (ic < 11) v = ic_t[ic];
        4: if (ic / 1000 < 9) v = te[ic / 1000];
        5: if (ic < 10) v = pa[ic];
        6: if (ic < 11) v = sk[ic];
        7: if (ic < 41) v = sp[ic];
        8: if (ic < 9) v = tu[ic];
        9: if (ic < 22) v = mk[ic];
        default: ;
      endcase
      if (v == -2) return 0;
      if (v == 0) return -1;
      b = v[7:0];
      return 1;
    endfunction

    function bit outside(int span, int p, int bound, bit neg);
      int d;
      d = span * (p - bound);
      return neg ? (d < 0) : (d > 0);
    endfunction

    // note an accepted point and queue its bytes
    function void note_point(point_t p);
      logic [7:0] s[$];
      logic [7:0] b;
      sym_t w;
      int sx, sy, r, m, i;
      bit slash;
      sx = sgn(span_x);
      sy = sgn(span_y);
      if (p.first) stopped = 0;
      if (suppress || stopped) return;
      if (outside(sx, p.x, clip_l, 1) || outside(sx, p.x, clip_r, 0) ||
          outside(sy, p.y, clip_b, 1) || outside(sy, p.y, clip_t, 0)) begin
        stopped = 1;
        return;
      end
      add_steps(s, p.xo, sx, BYTE_LEFT, BYTE_RIGHT);
      add_steps(s, p.yo, sy, BYTE_DOWN, BYTE_UP);
      slash = (p.cat == CAT_SPEC && p.code == CODE_SLASH);
      if (!slash) s.push_back(BYTE_SP_ON);
      r = 0;
      if (p.cat == CAT_WX) begin
        if (p.code < 110) begin
          w = wx_table(p.code);
          if (w[0] == 0) r = -1;
          else for (i = 0; i < 6 && w[i] != 0; i++) s.push_back(w[i]);
        end
      end else begin
        r = single(p.cat, p.code, b);
      end
      if (r < 0) begin
        stopped = 1;
        return;
      end
      if (r > 0) s.push_back(b);
      if (!slash) s.push_back(BYTE_SP_OFF);
      if (s.size() % 2) s.push_back(BYTE_PAD);
      m = s.size();
      s.push_front(p.y[7:0]);
      s.push_front(p.y[15:8]);
      s.push_front(p.x[7:0]);
      s.push_front(p.x[15:8]);
      s.push_front(BYTE_HDR5);
      s.push_front(BYTE_HDR4);
      s.push_front(BYTE_HDR3);
      s.push_front(BYTE_HDR2);
      s.push_front(8'(5 + m / 2));
      s.push_front(BYTE_HDR0);
      foreach (s[j]) pending.push_back('{s[j], j == s.size() - 1});
    endfunction

    // compare one received byte against the oldest expectation
    function void check_byte(logic [7:0] d, logic l);
      disp_byte_t e;
      if (pending.size() == 0) begin
        $error("unexpected byte %h last %b", d, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d !== e.data) begin
        $error("out_byte expected %h actual %h", e.data, d);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_byte expected %b actual %b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  // weather table rebuilt as a lookup for the predictor
  function automatic sym_t wx_table(int i);
    sym_t r;
    byte unsigned t[110][6] = '{
      '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},
      '{8'h1c,0,0,0,0,0},'{8'h1d,0,0,0,0,0},'{8'h1e,0,0,0,0,0},'{8'h1f,0,0,0,0,0},
      '{8'h20,0,0,0,0,0},'{8'h21,0,0,0,0,0},'{8'h22,0,0,0,0,0},'{8'h23,0,0,0,0,0},
      '{8'h24,0,0,0,0,0},'{8'h25,0,0,0,0,0},'{8'h26,0,0,0,0,0},'{8'h27,0,0,0,0,0},
      '{8'h28,0,0,0,0,0},'{8'h29,0,0,0,0,0},'{8'h2a,0,0,0,0,0},'{8'h2b,0,0,0,0,0},
      '{8'h2c,8'h31,0,0,0,0},'{8'h2d,8'h31,0,0,0,0},'{8'h2e,8'h31,0,0,0,0},
      '{8'h2f,8'h31,0,0,0,0},'{8'h30,8'h31,0,0,0,0},
      '{8'h36,8'h0b,8'h08,8'h2d,8'h0a,8'h31},'{8'h36,8'h0b,8'h08,8'h2e,8'h0a,8'h31},
      '{8'h36,8'h0b,8'h08,8'h4d,8'h0a,8'h31},
      '{8'h35,8'h31,0,0,0,0},'{8'h29,8'h31,0,0,0,0},
      '{8'h37,8'h09,8'h39,0,0,0},'{8'h37,0,0,0,0,0},'{8'h39,8'h08,8'h37,0,0,0},
      '{8'h3a,8'h09,8'h39,0,0,0},'{8'h3a,0,0,0,0,0},'{8'h39,8'h08,8'h3a,0,0,0},
      '{8'h3b,0,0,0,0,0},'{8'h3c,0,0,0,0,0},'{8'h3d,0,0,0,0,0},'{8'h3e,0,0,0,0,0},
      '{8'h48,8'h53,0,0,0,0},'{8'h3f,0,0,0,0,0},'{8'h40,8'h09,8'h39,0,0,0},
      '{8'h35,8'h09,8'h39,0,0,0},
      '{8'h40,0,0,0,0,0},'{8'h35,0,0,0,0,0},'{8'h39,8'h08,8'h40,0,0,0},
      '{8'h39,8'h08,8'h35,0,0,0},'{8'h41,0,0,0,0,0},'{8'h42,0,0,0,0,0},
      '{8'h2c,0,0,0,0,0},'{8'h2c,8'h2c,0,0,0,0},'{8'h43,0,0,0,0,0},
      '{8'h08,8'h2c,8'h0b,8'h2c,8'h0a,8'h2c},
      '{8'h43,8'h0b,8'h08,8'h2c,0,0},'{8'h08,8'h2c,8'h43,8'h2c,0,0},
      '{8'h44,0,0,0,0,0},'{8'h45,0,0,0,0,0},'{8'h49,0,0,0,0,0},
      '{8'h49,8'h0b,8'h08,8'h2c,0,0},
      '{8'h2d,0,0,0,0,0},'{8'h2d,8'h2d,0,0,0,0},'{8'h4f,0,0,0,0,0},
      '{8'h08,8'h2d,8'h0b,8'h2d,8'h0a,8'h2d},
      '{8'h4f,8'h0b,8'h08,8'h2d,0,0},'{8'h08,8'h2d,8'h4f,8'h2d,0,0},
      '{8'h46,0,0,0,0,0},'{8'h47,0,0,0,0,0},'{8'h2f,0,0,0,0,0},
      '{8'h2f,8'h0b,8'h08,8'h2e,0,0},
      '{8'h2e,0,0,0,0,0},'{8'h2e,8'h2e,0,0,0,0},'{8'h59,0,0,0,0,0},
      '{8'h08,8'h2e,8'h0b,8'h2e,8'h0a,8'h2e},
      '{8'h59,8'h0b,8'h08,8'h2e,0,0},'{8'h08,8'h2e,8'h59,8'h2e,0,0},
      '{8'h4a,0,0,0,0,0},'{8'h4b,0,0,0,0,0},'{8'h4c,0,0,0,0,0},'{8'h4d,0,0,0,0,0},
      '{8'h36,8'h0b,8'h08,8'h2d,0,0},'{8'h4e,8'h0b,8'h08,8'h2d,0,0},
      '{8'h36,8'h0b,8'h08,8'h4f,0,0},
      '{8'h36,8'h0b,8'h08,8'h2f,0,0},'{8'h4e,8'h0b,8'h08,8'h2f,0,0},
      '{8'h36,8'h0b,8'h08,8'h2e,0,0},
      '{8'h4e,8'h0b,8'h08,8'h2e,0,0},'{8'h36,8'h0b,8'h08,8'h4d,0,0},
      '{8'h4e,8'h0b,8'h08,8'h4d,0,0},
      '{8'h36,8'h0b,8'h08,8'h4d,0,0},'{8'h4e,8'h0b,8'h08,8'h4d,0,0},
      '{8'h29,8'h51,0,0,0,0},'{8'h29,8'h52,0,0,0,0},'{8'h29,8'h55,0,0,0,0},
      '{8'h29,8'h57,0,0,0,0},
      '{8'h29,8'h0b,8'h08,8'h2d,0,0},'{8'h29,8'h0b,8'h08,8'h4d,0,0},
      '{8'h58,8'h0b,8'h08,8'h2d,0,0},
      '{8'h29,8'h0b,8'h08,8'h37,0,0},'{8'h58,8'h0b,8'h08,8'h4d,0,0},
      '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},
      '{8'h29,8'h54,0,0,0,0},'{8'h29,8'h56,0,0,0,0},'{8'h29,8'h0b,8'h08,8'h2e,0,0},
      '{0,0,0,0,0,0},
      '{8'h58,8'h0b,8'h08,8'h2e,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}};
    for (int k = 0; k < 6; k++) r[k] = t[i][k];
    return r;
  endfunction

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               first_of_call = 0;
  logic [3:0]         category = '0;
  logic [13:0]        symbol_code = '0;
  logic signed [15:0] x_coord = '0;
  logic signed [15:0] y_coord = '0;
  logic signed [5:0]  x_offset = '0;
  logic signed [5:0]  y_offset = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [7:0]         out_byte;
  logic               last_byte;

  byte_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  symbol_to_display_byte_encoder u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .first_of_call, .category, .symbol_code,
    .x_coord, .y_coord, .x_offset, .y_offset,
    .out_valid, .out_stall, .out_byte, .last_byte
  );

  always #2 clk = ~clk;

  // receiver stall and result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_byte(out_byte, last_byte);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // send one point, with random gaps before it; valid stays up for a following point
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    first_of_call <= p.first;
    category <= p.cat;
    symbol_code <= p.code;
    x_coord <= p.x;
    y_coord <= p.y;
    x_offset <= p.xo;
    y_offset <= p.yo;
    do @(posedge clk); while (in_stall);
    board.note_point(p);
  endtask

  // stop sending and wait until all expected bytes have arrived plus the latency tail
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic point_t rand_point(bit wide);
    point_t p;
    int c;
    p.first = ($urandom_range(99) < 30);
    c = $urandom_range(99);
    p.cat = (c < 3) ? 4'($urandom_range(15)) : 4'($urandom_range(9, 1));
    case ($urandom_range(3))
      0: p.code = 14'($urandom);
      1: p.code = (p.cat == CAT_TEND) ? 14'($urandom_range(9999)) : 14'($urandom_range(45));
      default: p.code = (p.cat == CAT_TEND) ? 14'($urandom_range(8999))
                        : (p.cat == CAT_WX) ? 14'($urandom_range(109)) : 14'($urandom_range(40));
    endcase
    if (wide) begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
    end else begin
      p.x = 16'($urandom_range(32767));
      p.y = 16'($urandom_range(32767));
    end
    p.xo = 6'($urandom);
    p.yo = 6'($urandom);
    if ($urandom_range(3) != 0) begin
      p.xo = 6'($signed($urandom_range(60)) - 30);
      p.yo = 6'($signed($urandom_range(60)) - 30);
    end
    return p;
  endfunction

  initial begin
    point_t p;
    int sent;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, all categories, slash, blank, clip, suppress
    send_idle_pct = 0;
    send_point('{1, CAT_WX, 14'd25, 16'sd100, 16'sd200, 6'sd30, -6'sd30});
    send_point('{0, CAT_WX, 14'd53, 16'sd32767, 16'sd0, -6'sd32, 6'sd31});
    send_point('{0, CAT_CLOUD, 14'd29, 16'sd0, 16'sd32767, 6'sd1, -6'sd1});
    send_point('{0, CAT_ICE, 14'd8, 16'sd5, 16'sd5, 6'sd0, 6'sd0});
    send_point('{0, CAT_TEND, 14'd8999, 16'sd5, 16'sd5, 6'sd3, 6'sd2});
    send_point('{0, CAT_TEND, 14'd16383, 16'sd5, 16'sd5, 6'sd0, 6'sd0});
    send_point('{0, CAT_PAST, 14'd9, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_SKY, 14'd0, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_SPEC, CODE_SLASH, 16'sd7, 16'sd7, 6'sd1, 6'sd0});
    send_point('{0, CAT_TURB, 14'd6, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_MARK, 14'd21, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, 4'd0, 14'd3, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, 4'd15, 14'd3, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_SPEC, 14'd500, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_CLOUD, 14'd10, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_SKY, 14'd1, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{1, CAT_SKY, 14'd1, -16'sd1, 16'sd7, 6'sd0, 6'sd0});
    send_point('{0, CAT_SKY, 14'd2, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    send_point('{1, CAT_WX, 14'd107, -16'sd32768, 16'sd0, 6'sd0, 6'sd0});
    drain();
    write_reg(REG_SUPPRESS, 16'd1);
    send_point('{1, CAT_SKY, 14'd3, 16'sd7, 16'sd7, 6'sd0, 6'sd0});
    drain();
    write_reg(REG_SUPPRESS, 16'd0);
    write_reg(REG_SPAN_X, 16'h0002);
    write_reg(REG_SPAN_Y, 16'h0000);
    write_reg(REG_CLIP_L, 16'h8000);
    write_reg(REG_CLIP_R, 16'h7fff);
    write_reg(REG_CLIP_B, 16'hffff);
    write_reg(REG_CLIP_T, 16'h0000);
    send_point('{1, CAT_MARK, 14'd2, 16'sd9, -16'sd30000, 6'sd30, 6'sd31});
    send_point('{1, CAT_MARK, 14'd3, 16'sd9, -16'sd30000, -6'sd32, -6'sd30});
    drain();

    // random phases with different settings and idle patterns
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      bit wide;
      drain();
      case (ph % 3)
        0: begin send_idle_pct = 8; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 8; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wide = (ph >= 3);
      write_reg(REG_SPAN_X, wide ? 16'($urandom_range(3)) : 16'd1);
      write_reg(REG_SPAN_Y, wide ? 16'($urandom_range(3)) : 16'd1);
      write_reg(REG_CLIP_L, wide ? 16'($urandom_range(65535)) : 16'd0);
      write_reg(REG_CLIP_R, wide ? 16'hffff ^ 16'($urandom_range(255)) : 16'h7fff);
      write_reg(REG_CLIP_B, wide ? 16'h8000 : 16'd0);
      write_reg(REG_CLIP_T, wide ? 16'h7fff : 16'h7fff);
      write_reg(REG_SUPPRESS, (ph == 4) ? 16'($urandom_range(1)) : 16'd0);
      for (int i = 0; i < 72; i++) begin
        p = rand_point(wide && ($urandom_range(3) == 0));
        send_point(p);
        sent++;
        if (sent == 100) drain();
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS symbol_to_display_byte_encoder");
    end else begin
      $display("FAIL symbol_to_display_byte_encoder");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL symbol_to_display_byte_encoder");
    $finish;
  end

endmodule
